FILE: rtl/assert_macros.svh
// Assertion macros used by the top-level RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent check on clk_i, off while rst_ni is low.
`define TBRA_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);

// Condition that must never be seen on clk_i.
`define TBRA_NEVER(name, cond, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) \
    else $error(msg);

`endif

FILE: rtl/tbra_pkg.sv
// Types and constants of the tipping-bucket rain accumulator.
package tbra_pkg;

  localparam int unsigned CNT_W  = 32;
  localparam int unsigned SLOT_W = 16;
  localparam int unsigned WSUM_W = 22;
  localparam int unsigned MM_W   = 24;
  localparam int unsigned DB_W   = 16;
  localparam int unsigned TS_W   = 48;
  localparam int unsigned RAIN_W = 56;
  localparam int unsigned RATE_W = 46;

  localparam logic [SLOT_W-1:0] SLOT_MAX = 16'hFFFF;
  localparam logic [WSUM_W-1:0] WSUM_MAX = 22'h3FFFFF;

  localparam logic [DB_W-1:0] DEBOUNCE_RST = 16'd250;
  localparam logic [MM_W-1:0] MM_RST       = 24'd18310;
  localparam logic [9:0]      US_PER_MS    = 10'd1000;

  // request codes
  localparam logic [2:0] REQ_EDGE  = 3'd0;
  localparam logic [2:0] REQ_TICK  = 3'd1;
  localparam logic [2:0] REQ_CLR15 = 3'd2;
  localparam logic [2:0] REQ_CLR1  = 3'd3;
  localparam logic [2:0] REQ_SIM   = 3'd4;

  // intensity classes and their rate limits (Q.16 mm/h)
  localparam logic [2:0] CLS_NONE     = 3'd0;
  localparam logic [2:0] CLS_LIGHT    = 3'd1;
  localparam logic [2:0] CLS_MODERATE = 3'd2;
  localparam logic [2:0] CLS_HEAVY    = 3'd3;
  localparam logic [2:0] CLS_VIOLENT  = 3'd4;

  localparam logic [RATE_W-1:0] LIM_NONE     = 46'd655;
  localparam logic [RATE_W-1:0] LIM_LIGHT    = 46'd163840;
  localparam logic [RATE_W-1:0] LIM_MODERATE = 46'd498074;
  localparam logic [RATE_W-1:0] LIM_HEAVY    = 46'd3276800;

  typedef struct packed {
    logic [2:0]       req_type;
    logic [TS_W-1:0]  timestamp_us;
    logic [CNT_W-1:0] minute_number;
    logic [4:0]       day_of_month;
    logic             clock_valid;
  } in_t;

  typedef struct packed {
    logic              edge_accepted;
    logic [RAIN_W-1:0] rain_1min_mm;
    logic [RAIN_W-1:0] rain_15min_mm;
    logic [RAIN_W-1:0] rain_today_mm;
    logic [RATE_W-1:0] rain_rate_mm_h;
    logic [CNT_W-1:0]  pulses_today;
    logic [CNT_W-1:0]  pulses_total;
    logic [2:0]        intensity_class;
  } out_t;

  // per-cell slot controls
  typedef struct packed {
    logic clr;
    logic shift;
    logic add;
  } cell_ctrl_t;

  function automatic logic [2:0] classify(input logic [RATE_W-1:0] r);
    logic [2:0] c;
    if (r <= LIM_NONE) c = CLS_NONE;
    else if (r < LIM_LIGHT) c = CLS_LIGHT;
    else if (r < LIM_MODERATE) c = CLS_MODERATE;
    else if (r < LIM_HEAVY) c = CLS_HEAVY;
    else c = CLS_VIOLENT;
    return c;
  endfunction

endpackage

FILE: rtl/tbra_cell.sv
// One minute slot of the rain window ring: clear, shift from neighbor or saturating add.
module tbra_cell (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  tbra_pkg::cell_ctrl_t         ctrl_i,
  input  logic [tbra_pkg::SLOT_W-1:0]  nbr_i,
  input  logic [tbra_pkg::CNT_W-1:0]   add_i,
  output logic [tbra_pkg::SLOT_W-1:0]  val_o,
  output logic [tbra_pkg::SLOT_W-1:0]  inc_o
);
  import tbra_pkg::*;

  logic [SLOT_W-1:0] val_q, val_d, sat_w;
  logic [CNT_W:0]    sum_w;

  assign sum_w = {1'b0, add_i} + (CNT_W+1)'(val_q);
  assign sat_w = (sum_w > (CNT_W+1)'(SLOT_MAX)) ? SLOT_MAX : sum_w[SLOT_W-1:0];
  // growth of the slot, for the running window sum
  assign inc_o = sat_w - val_q;
  assign val_o = val_q;

  always_comb begin
    val_d = val_q;
    if (ctrl_i.clr) begin
      val_d = '0;
    end else if (ctrl_i.shift) begin
      val_d = nbr_i;
    end else if (ctrl_i.add) begin
      val_d = sat_w;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      val_q <= '0;
    end else begin
      val_q <= val_d;
    end
  end

endmodule

FILE: rtl/tipping_bucket_rain_accumulator_unit.sv
// Top level: rain tip counter with a ring of minute-slot cells and one shared multiplier.
// Steps: EXEC; EDGE for a gauge edge; RATE, RMUL for a simulated tip; for a tick that moves
// the minute, one ROT step per slot moved (up to SLOTS), RATE, RMUL; then MUL and OUT.
// One item at a time: the next input transfer is taken the cycle after the result is loaded.
// Reset (async, active low) clears all counts and every slot cell at once; registers
// take their reset values (debounce 250 ms, 18310 Q.16 mm per tip).
`include "assert_macros.svh"

module tipping_bucket_rain_accumulator_unit #(
  parameter int unsigned SLOTS = 60
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  tbra_pkg::in_t      in_data_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output tbra_pkg::out_t     out_data_o,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);
  import tbra_pkg::*;

  localparam int unsigned NEXT  = (SLOTS > 1) ? 1 : 0;
  localparam int unsigned SUM_W = $clog2(SLOTS * 65535 + 1);
  localparam int unsigned CMP_W = (SUM_W > WSUM_W) ? SUM_W : WSUM_W;
  localparam int unsigned ROT_W = $clog2(SLOTS + 1);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_EXEC = 3'd1;
  localparam logic [2:0] S_EDGE = 3'd2;
  localparam logic [2:0] S_ROT  = 3'd3;
  localparam logic [2:0] S_RATE = 3'd4;
  localparam logic [2:0] S_RMUL = 3'd5;
  localparam logic [2:0] S_MUL  = 3'd6;
  localparam logic [2:0] S_OUT  = 3'd7;

  logic [2:0]        state_q, state_d;
  in_t               in_q;
  out_t              out_q;
  logic              out_valid_q;
  logic [DB_W-1:0]   debounce_q;
  logic [MM_W-1:0]   mm_q;
  logic [CNT_W-1:0]  pending_q, total_q, c1_q, c15_q, cday_q, last_min_q;
  logic [TS_W-1:0]   last_edge_q;
  logic [4:0]        last_day_q;
  logic              day_known_q;
  logic [SUM_W-1:0]  sum_q, sum_d;
  logic [WSUM_W-1:0] wsum_q, wsum_d;
  logic [RATE_W-1:0] rate_q;
  logic [ROT_W-1:0]  rot_q;
  logic [TS_W:0]     thr_q;
  logic              acc_q;
  logic [1:0]        mi_q;
  logic [RAIN_W-1:0] p1_q, p15_q, pday_q;

  logic              accept_w, cfg_wr_w, out_free_w;
  logic              head_add_en;
  logic [CNT_W-1:0]  head_add;
  logic [CNT_W-1:0]  mul_a;
  logic [RAIN_W-1:0] mul_p;
  logic [25:0]       db_us;
  logic              day_roll;
  logic [CNT_W-1:0]  min_diff;
  logic [ROT_W-1:0]  missed;
  logic [CMP_W-1:0]  sum_ext;

  cell_ctrl_t        ctrl_w   [SLOTS];
  logic [SLOT_W-1:0] slot_val [SLOTS];
  logic [SLOT_W-1:0] inc_w    [SLOTS];

  assign accept_w    = in_valid_i && !in_stall_o;
  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;
  assign out_free_w  = !out_valid_q || !out_stall_i;

  // configuration port
  assign pready   = 1'b1;
  assign cfg_wr_w = psel && penable && pwrite && pready;
  assign prdata   = paddr[2] ? 32'(mm_q) : 32'(debounce_q);

  // minute slot ring, cell 0 is the current slot
  for (genvar g = 0; g < SLOTS; g++) begin : g_cell
    localparam int unsigned NB = (g + 1) % SLOTS;
    tbra_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .ctrl_i (ctrl_w[g]),
      .nbr_i  (slot_val[NB]),
      .add_i  (head_add),
      .val_o  (slot_val[g]),
      .inc_o  (inc_w[g])
    );
  end

  assign head_add_en = (state_q == S_EXEC) &&
                       ((in_q.req_type == REQ_TICK) || (in_q.req_type == REQ_SIM));
  assign head_add    = (in_q.req_type == REQ_SIM) ? CNT_W'(1) : pending_q;

  always_comb begin
    for (int i = 0; i < SLOTS; i++) begin
      ctrl_w[i] = '0;
      if (state_q == S_ROT) begin
        if (i == 0) ctrl_w[i].clr = 1'b1;
        else ctrl_w[i].shift = 1'b1;
      end
    end
    ctrl_w[0].add = head_add_en;
  end

  // running sum of all slots
  always_comb begin
    sum_d = sum_q;
    if (state_q == S_ROT) begin
      sum_d = sum_q - SUM_W'(slot_val[NEXT]);
    end else if (head_add_en) begin
      sum_d = sum_q + SUM_W'(inc_w[0]);
    end
  end

  assign sum_ext = CMP_W'(sum_q);
  assign wsum_d  = (sum_ext > CMP_W'(WSUM_MAX)) ? WSUM_MAX : WSUM_W'(sum_ext);

  // shared multiplier
  always_comb begin
    case (mi_q)
      2'd0:    mul_a = c1_q;
      2'd1:    mul_a = c15_q;
      default: mul_a = cday_q;
    endcase
    if (state_q == S_RMUL) mul_a = CNT_W'(wsum_q);
  end
  assign mul_p = RAIN_W'(mul_a) * RAIN_W'(mm_q);

  assign db_us    = 26'(debounce_q) * 26'(US_PER_MS);
  assign day_roll = day_known_q && (in_q.day_of_month != last_day_q) && in_q.clock_valid;
  assign min_diff = in_q.minute_number - last_min_q;
  assign missed   = (min_diff > CNT_W'(SLOTS)) ? ROT_W'(SLOTS) : min_diff[ROT_W-1:0];

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: if (accept_w) state_d = S_EXEC;
      S_EXEC: begin
        case (in_q.req_type)
          REQ_EDGE: state_d = S_EDGE;
          REQ_SIM:  state_d = S_RATE;
          REQ_TICK: begin
            if ((last_min_q != '0) && (in_q.minute_number > last_min_q)) state_d = S_ROT;
            else state_d = S_MUL;
          end
          default:  state_d = S_MUL;
        endcase
      end
      S_EDGE: state_d = S_MUL;
      S_ROT:  if (rot_q == ROT_W'(1)) state_d = S_RATE;
      S_RATE: state_d = S_RMUL;
      S_RMUL: state_d = S_MUL;
      S_MUL:  if (mi_q == 2'd2) state_d = S_OUT;
      S_OUT:  if (out_free_w) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
      debounce_q  <= DEBOUNCE_RST;
      mm_q        <= MM_RST;
      pending_q   <= '0;
      total_q     <= '0;
      c1_q        <= '0;
      c15_q       <= '0;
      cday_q      <= '0;
      last_edge_q <= '0;
      last_day_q  <= '0;
      day_known_q <= 1'b0;
      last_min_q  <= '0;
      sum_q       <= '0;
      wsum_q      <= '0;
      rate_q      <= '0;
      rot_q       <= '0;
      acc_q       <= 1'b0;
      mi_q        <= '0;
    end else begin
      state_q <= state_d;
      sum_q   <= sum_d;
      if (cfg_wr_w) begin
        if (paddr[2]) mm_q <= pwdata[MM_W-1:0];
        else debounce_q <= pwdata[DB_W-1:0];
      end
      if ((state_q == S_OUT) && out_free_w) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_EXEC: begin
          acc_q <= 1'b0;
          case (in_q.req_type)
            REQ_TICK: begin
              pending_q <= '0;
              if (!day_known_q) begin
                last_day_q  <= in_q.day_of_month;
                day_known_q <= 1'b1;
              end else if (day_roll) begin
                last_day_q <= in_q.day_of_month;
              end
              c1_q   <= c1_q + pending_q;
              c15_q  <= c15_q + pending_q;
              cday_q <= (day_roll ? '0 : cday_q) + pending_q;
              if (last_min_q == '0) begin
                last_min_q <= in_q.minute_number;
              end else if (in_q.minute_number > last_min_q) begin
                last_min_q <= in_q.minute_number;
                rot_q      <= missed;
              end
            end
            REQ_CLR15: c15_q <= '0;
            REQ_CLR1:  c1_q  <= '0;
            REQ_SIM: begin
              total_q <= total_q + CNT_W'(1);
              c1_q    <= c1_q + CNT_W'(1);
              c15_q   <= c15_q + CNT_W'(1);
              cday_q  <= cday_q + CNT_W'(1);
            end
            default: ;
          endcase
        end
        S_EDGE: begin
          if ({1'b0, in_q.timestamp_us} > thr_q) begin
            pending_q   <= pending_q + CNT_W'(1);
            total_q     <= total_q + CNT_W'(1);
            last_edge_q <= in_q.timestamp_us;
            acc_q       <= 1'b1;
          end
        end
        S_ROT:  rot_q  <= rot_q - ROT_W'(1);
        S_RATE: wsum_q <= wsum_d;
        S_RMUL: rate_q <= mul_p[RATE_W-1:0];
        S_MUL:  mi_q   <= (mi_q == 2'd2) ? 2'd0 : mi_q + 2'd1;
        default: ;
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (accept_w) in_q <= in_data_i;
    if (state_q == S_EXEC) thr_q <= {1'b0, last_edge_q} + (TS_W+1)'(db_us);
    if (state_q == S_MUL) begin
      case (mi_q)
        2'd0:    p1_q   <= mul_p;
        2'd1:    p15_q  <= mul_p;
        default: pday_q <= mul_p;
      endcase
    end
    if ((state_q == S_OUT) && out_free_w) begin
      out_q.edge_accepted   <= acc_q;
      out_q.rain_1min_mm    <= p1_q;
      out_q.rain_15min_mm   <= p15_q;
      out_q.rain_today_mm   <= pday_q;
      out_q.rain_rate_mm_h  <= rate_q;
      out_q.pulses_today    <= cday_q;
      out_q.pulses_total    <= total_q;
      out_q.intensity_class <= classify(rate_q);
    end
  end

  `TBRA_ASSERT(a_stall_after_transfer, accept_w |=> in_stall_o, "input taken while busy")
  `TBRA_ASSERT(a_rot_count_live, (state_q == S_ROT) |-> (rot_q != '0), "ring turn, none left")
  `TBRA_NEVER(a_sum_below_head, sum_q < SUM_W'(slot_val[0]), "window sum below current slot")

endmodule

FILE: tb/tipping_bucket_rain_accumulator_unit_tb.sv
// Testbench for the tipping-bucket rain accumulator: directed cases, random traffic, checks.
`timescale 1ns / 1ps

module tipping_bucket_rain_accumulator_unit_tb;
  import tbra_pkg::*;

  localparam int unsigned SLOTS = 60;
  localparam int unsigned HOLD_LEN = 300;
  localparam int unsigned TAIL_CYCLES = 100;
  localparam int unsigned BURST_EDGES = 40;

  localparam logic [2:0] ADDR_DEBOUNCE = 3'd0;
  localparam logic [2:0] ADDR_MM = 3'd4;

  // request codes the block must ignore
  localparam logic [2:0] REQ_RSVD_A = 3'd5;
  localparam logic [2:0] REQ_RSVD_B = 3'd6;
  localparam logic [2:0] REQ_RSVD_C = 3'd7;

  logic clk;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  in_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_t out_data;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [2:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  tipping_bucket_rain_accumulator_unit #(.SLOTS(SLOTS)) uut (
    .clk_i(clk),
    .rst_ni(rst_n),
    .in_valid_i(in_valid),
    .in_stall_o(in_stall),
    .in_data_i(in_data),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .out_data_o(out_data),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready)
  );

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  // ---------------- predicted gauge state ----------------
  logic [DB_W-1:0] cfg_debounce = DEBOUNCE_RST;
  logic [MM_W-1:0] cfg_mm = MM_RST;
  logic [CNT_W-1:0] pend_tips = '0;
  logic [CNT_W-1:0] tip_total = '0;
  logic [TS_W-1:0] last_edge_us = '0;
  logic [CNT_W-1:0] cnt_1min = '0;
  logic [CNT_W-1:0] cnt_15min = '0;
  logic [CNT_W-1:0] cnt_day = '0;
  logic [4:0] day_seen = '0;
  logic day_valid = 1'b0;
  logic [CNT_W-1:0] minute_seen = '0;
  int unsigned slot_idx = 0;
  logic [SLOT_W-1:0] slot_cnt [SLOTS];
  logic [WSUM_W-1:0] win_sum = '0;
  logic [RATE_W-1:0] rate_q16 = '0;

  initial begin
    for (int i = 0; i < SLOTS; i++) slot_cnt[i] = '0;
  end

  out_t expected_reports [$];
  out_t want;
  int unsigned mismatches = 0;
  int unsigned items_sent = 0;
  int unsigned reports_seen = 0;

  // stimulus control
  int unsigned snd_idle = 0;
  int unsigned rcv_idle = 0;
  bit hold_req = 1'b0;
  int unsigned hold_left = 0;
  logic [TS_W-1:0] now_us = 48'd1_000_000_000;
  logic [CNT_W-1:0] minute_now = 32'd1000;
  logic [4:0] day_now = 5'd2;

  function automatic void slot_add(input logic [CNT_W-1:0] n);
    logic [CNT_W:0] v;
    v = {1'b0, n} + slot_cnt[slot_idx];
    slot_cnt[slot_idx] = (v > SLOT_MAX) ? SLOT_MAX : v[SLOT_W-1:0];
  endfunction

  function automatic void rate_refresh();
    logic [31:0] s;
    s = '0;
    for (int i = 0; i < SLOTS; i++) s += slot_cnt[i];
    win_sum = (s > WSUM_MAX) ? WSUM_MAX : s[WSUM_W-1:0];
    rate_q16 = RATE_W'(win_sum) * RATE_W'(cfg_mm);
  endfunction

  function automatic logic [2:0] rate_class(input logic [RATE_W-1:0] r);
    if (r <= LIM_NONE) return CLS_NONE;
    if (r < LIM_LIGHT) return CLS_LIGHT;
    if (r < LIM_MODERATE) return CLS_MODERATE;
    if (r < LIM_HEAVY) return CLS_HEAVY;
    return CLS_VIOLENT;
  endfunction

  // Applies one item to the predicted state and returns the report it should produce.
  function automatic out_t gauge_apply(input in_t it);
    out_t r;
    logic acc;
    logic [63:0] gate_us;
    logic [CNT_W-1:0] n;
    logic [CNT_W-1:0] gap;
    acc = 1'b0;
    case (it.req_type)
      REQ_EDGE: begin
        gate_us = 64'(last_edge_us) + 64'(cfg_debounce) * 64'd1000;
        if (64'(it.timestamp_us) > gate_us) begin
          pend_tips++;
          tip_total++;
          last_edge_us = it.timestamp_us;
          acc = 1'b1;
        end
      end
      REQ_TICK: begin
        n = pend_tips;
        pend_tips = '0;
        if (!day_valid) begin
          day_seen = it.day_of_month;
          day_valid = 1'b1;
        end else if (it.day_of_month != day_seen && it.clock_valid) begin
          cnt_day = '0;
          day_seen = it.day_of_month;
        end
        if (n != 0) begin
          cnt_15min += n;
          cnt_1min += n;
          cnt_day += n;
          slot_add(n);
        end
        if (minute_seen == 0) begin
          minute_seen = it.minute_number;
        end else if (it.minute_number > minute_seen) begin
          gap = it.minute_number - minute_seen;
          if (gap > SLOTS) gap = SLOTS;
          for (int m = 0; m < gap; m++) begin
            slot_idx = (slot_idx + 1) % SLOTS;
            slot_cnt[slot_idx] = '0;
          end
          minute_seen = it.minute_number;
          rate_refresh();
        end
      end
      REQ_CLR15: cnt_15min = '0;
      REQ_CLR1: cnt_1min = '0;
      REQ_SIM: begin
        tip_total++;
        cnt_15min++;
        cnt_1min++;
        cnt_day++;
        slot_add(32'd1);
        rate_refresh();
      end
      default: ;
    endcase
    r.edge_accepted = acc;
    r.rain_1min_mm = RAIN_W'(cnt_1min) * RAIN_W'(cfg_mm);
    r.rain_15min_mm = RAIN_W'(cnt_15min) * RAIN_W'(cfg_mm);
    r.rain_today_mm = RAIN_W'(cnt_day) * RAIN_W'(cfg_mm);
    r.rain_rate_mm_h = rate_q16;
    r.pulses_today = cnt_day;
    r.pulses_total = tip_total;
    r.intensity_class = rate_class(rate_q16);
    return r;
  endfunction

  // ---------------- result side ----------------
  task automatic check_field(input string fname, input logic [63:0] e, input logic [63:0] a);
    if (e !== a) begin
      $error("%s: expected %0h, got %0h", fname, e, a);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (expected_reports.size() == 0) begin
        $error("result transfer with no report pending");
        mismatches++;
      end else begin
        want = expected_reports.pop_front();
        reports_seen++;
        check_field("edge_accepted", 64'(want.edge_accepted), 64'(out_data.edge_accepted));
        check_field("rain_1min_mm", 64'(want.rain_1min_mm), 64'(out_data.rain_1min_mm));
        check_field("rain_15min_mm", 64'(want.rain_15min_mm), 64'(out_data.rain_15min_mm));
        check_field("rain_today_mm", 64'(want.rain_today_mm), 64'(out_data.rain_today_mm));
        check_field("rain_rate_mm_h", 64'(want.rain_rate_mm_h), 64'(out_data.rain_rate_mm_h));
        check_field("pulses_today", 64'(want.pulses_today), 64'(out_data.pulses_today));
        check_field("pulses_total", 64'(want.pulses_total), 64'(out_data.pulses_total));
        check_field("intensity_class", 64'(want.intensity_class),
                    64'(out_data.intensity_class));
      end
    end
    // long hold-off is counted here, random stalls otherwise
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else if (hold_req) begin
      hold_req = 1'b0;
      hold_left = HOLD_LEN - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < rcv_idle);
    end
  end

  // ---------------- item side ----------------
  task automatic send_item(input in_t it);
    while ($urandom_range(99) < snd_idle) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= it;
    do @(posedge clk); while (in_stall);
    expected_reports.push_back(gauge_apply(it));
    items_sent++;
  endtask

  task automatic wait_drain();
    while (expected_reports.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic [2:0] addr, input logic [31:0] data);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (addr == ADDR_DEBOUNCE) cfg_debounce = data[DB_W-1:0];
    else if (addr == ADDR_MM) cfg_mm = data[MM_W-1:0];
    @(posedge clk);
  endtask

  task automatic set_config(input logic [DB_W-1:0] db, input logic [MM_W-1:0] mm);
    in_valid <= 1'b0;
    wait_drain();
    write_reg(ADDR_DEBOUNCE, 32'(db));
    write_reg(ADDR_MM, 32'(mm));
  endtask

  function automatic in_t mk(input logic [2:0] req, input logic [TS_W-1:0] ts,
                             input logic [CNT_W-1:0] minute, input logic [4:0] day,
                             input logic cv);
    in_t it;
    it.req_type = req;
    it.timestamp_us = ts;
    it.minute_number = minute;
    it.day_of_month = day;
    it.clock_valid = cv;
    return it;
  endfunction

  function automatic in_t next_random_item();
    in_t it;
    int unsigned sel;
    int unsigned k;
    it.req_type = REQ_EDGE;
    it.timestamp_us = TS_W'({$urandom, $urandom});
    it.minute_number = $urandom;
    it.day_of_month = 5'($urandom_range(1, 31));
    it.clock_valid = 1'($urandom_range(1));
    sel = $urandom_range(99);
    if (sel < 45) begin
      k = $urandom_range(9);
      if (k < 7) begin
        now_us += TS_W'(cfg_debounce) * TS_W'(1000) + TS_W'($urandom_range(1, 5000));
        it.timestamp_us = now_us;
      end else if (k < 9) begin
        // inside the debounce window
        it.timestamp_us = now_us + TS_W'($urandom_range(0, 32'(cfg_debounce) * 1000));
      end else begin
        it.timestamp_us = now_us - TS_W'($urandom_range(0, 1000000));
      end
    end else if (sel < 75) begin
      it.req_type = REQ_TICK;
      k = $urandom_range(99);
      if (k < 35) minute_now += 1;
      else if (k < 45) minute_now += $urandom_range(2, 5);
      else if (k < 50) minute_now += $urandom_range(SLOTS + 1, SLOTS + 30);
      if ($urandom_range(9) == 0) day_now = 5'($urandom_range(1, 31));
      it.minute_number = minute_now;
      it.day_of_month = day_now;
      it.clock_valid = ($urandom_range(9) != 0);
    end else if (sel < 80) begin
      it.req_type = REQ_CLR15;
    end else if (sel < 85) begin
      it.req_type = REQ_CLR1;
    end else if (sel < 95) begin
      it.req_type = REQ_SIM;
    end else begin
      it.req_type = REQ_RSVD_A + 3'($urandom_range(2));
    end
    return it;
  endfunction

  task automatic run_random(input int unsigned count);
    repeat (count) send_item(next_random_item());
  endtask

  // ---------------- tests ----------------
  task automatic test_special_cases();
    send_item(mk(REQ_RSVD_A, '0, '0, '0, 1'b0));
    send_item(mk(REQ_EDGE, '0, '0, 5'd1, 1'b0));        // at time zero, never passes
    send_item(mk(REQ_EDGE, 48'd250000, '0, 5'd1, 1'b0)); // exactly on the debounce limit
    send_item(mk(REQ_EDGE, 48'd250001, '0, 5'd1, 1'b0));
    send_item(mk(REQ_EDGE, 48'd100, '0, 5'd1, 1'b0));    // earlier than last edge
    send_item(mk(REQ_TICK, '0, 32'd0, 5'd1, 1'b1));     // first day; minute 0 stays unseen
    send_item(mk(REQ_TICK, '0, 32'd10, 5'd1, 1'b1));    // first minute
    send_item(mk(REQ_EDGE, 48'd600000, '0, 5'd1, 1'b1));
    send_item(mk(REQ_TICK, '0, 32'd10, 5'd1, 1'b1));    // same minute, no slot move
    send_item(mk(REQ_SIM, '0, '0, '0, 1'b0));
    send_item(mk(REQ_TICK, '0, 32'd11, 5'd1, 1'b1));
    send_item(mk(REQ_TICK, '0, 32'd11, 5'd2, 1'b0));    // day change with bad clock
    send_item(mk(REQ_EDGE, 48'd900000, '0, 5'd1, 1'b1));
    send_item(mk(REQ_TICK, '0, 32'd12, 5'd2, 1'b1));    // rollover
    send_item(mk(REQ_SIM, '0, '0, '0, 1'b1));
    send_item(mk(REQ_TICK, '0, 32'd200, 5'd2, 1'b1));   // gap wider than the window
    send_item(mk(REQ_CLR15, '0, '0, '0, 1'b0));
    send_item(mk(REQ_CLR1, '0, '0, '0, 1'b0));
    send_item(mk(REQ_RSVD_B, {TS_W{1'b1}}, {CNT_W{1'b1}}, 5'd31, 1'b1));
    send_item(mk(REQ_RSVD_C, '0, '0, '0, 1'b0));
  endtask

  task automatic test_backpressure();
    hold_req = 1'b1;
    run_random(12);
    in_valid <= 1'b0;
    wait_drain();
  endtask

  task automatic test_config_sweep();
    set_config(16'd0, 24'd0);
    run_random(75);
    set_config(16'hFFFF, 24'hFFFFFF);
    run_random(75);
    snd_idle = 68;
    rcv_idle = 38;
    set_config(16'($urandom), 24'($urandom));
    run_random(75);
    set_config(16'($urandom_range(1, 2000)), 24'($urandom_range(1, 2000)));
    run_random(75);
    snd_idle = 0;
    rcv_idle = 0;
    set_config(DEBOUNCE_RST, MM_RST);
    run_random(75);
  endtask

  // closely spaced edges within one minute, drained into a single slot
  task automatic test_edge_burst();
    set_config(16'd0, MM_RST);
    repeat (BURST_EDGES) begin
      now_us += 48'd1;
      send_item(mk(REQ_EDGE, now_us, $urandom, 5'($urandom_range(1, 31)), 1'b1));
    end
    send_item(mk(REQ_TICK, '0, minute_now, day_now, 1'b1));
    send_item(mk(REQ_SIM, '0, '0, '0, 1'b0));
    minute_now += 1;
    send_item(mk(REQ_TICK, '0, minute_now, day_now, 1'b1));
  endtask

  // largest timestamp and minute last: nothing can follow them
  task automatic test_field_extremes();
    send_item(mk(REQ_EDGE, {TS_W{1'b1}}, '0, 5'd31, 1'b0));
    send_item(mk(REQ_EDGE, {TS_W{1'b1}}, '0, 5'd31, 1'b0));
    send_item(mk(REQ_TICK, '0, {CNT_W{1'b1}}, 5'd31, 1'b1));
    send_item(mk(REQ_TICK, '0, '0, 5'd1, 1'b0));
    send_item(mk(REQ_SIM, {TS_W{1'b1}}, {CNT_W{1'b1}}, 5'd31, 1'b1));
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    snd_idle = 38;
    rcv_idle = 68;
    test_special_cases();
    test_backpressure();
    test_config_sweep();
    test_edge_burst();
    test_field_extremes();
    in_valid <= 1'b0;
    wait_drain();
    repeat (TAIL_CYCLES) @(posedge clk);
    $display("Covered %0d item transfers and %0d checked reports: debounce, rollover,",
             items_sent, reports_seen);
    $display("minute gaps, edge bursts, register extremes and back-pressure.");
    if (mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  initial begin
    #100_000_000;
    $display("timeout with %0d reports outstanding", expected_reports.size());
    $display("CHECKS FAILED");
    $finish;
  end

endmodule

FILE: tipping_bucket_rain_accumulator_unit.f
+incdir+rtl
rtl/tbra_pkg.sv
rtl/tbra_cell.sv
rtl/tipping_bucket_rain_accumulator_unit.sv
tb/tipping_bucket_rain_accumulator_unit_tb.sv
